/* rtl/sme_pkg.sv */
package sme_pkg;

   // Default geometry
   localparam int MATRIX_WIDTH_DEF  = 32;
   localparam int MATRIX_HEIGHT_DEF = 16;
   localparam int STORE_BYTES_DEF   = 1536;

   // Internal coordinate, pixel index and byte address widths (cover the parameter ranges)
   localparam int COORD_W = 11;
   localparam int PIX_W   = 18;
   localparam int BADDR_W = 20;

   // Action codes
   localparam logic [2:0] ACT_CLEAR = 3'd0;
   localparam logic [2:0] ACT_DIM   = 3'd1;
   localparam logic [2:0] ACT_POINT = 3'd2;
   localparam logic [2:0] ACT_LINE  = 3'd3;
   localparam logic [2:0] ACT_RECT  = 3'd4;
   localparam logic [2:0] ACT_READ  = 3'd5;

   // Divider result bundle
   typedef struct packed {
      logic       done;
      logic [7:0] quotient;
      logic [7:0] remainder;
   } div_result_type;

   // byte * factor / 256, saturated at 255
   function automatic logic [7:0] dim_byte(input logic [7:0] b, input logic [8:0] f);
      logic [16:0] prod;
      prod = 17'(b) * 17'(f);
      if (prod[16]) begin
         return 8'hFF;
      end
      return prod[15:8];
   endfunction

endpackage

/* rtl/serpentine_matrix_draw_engine_core.sv */
// Clear and dim sweep the frame RAM one byte per cycle; dim reads each byte and writes it back scaled.
// Point: index, address, three byte writes; read: one RAM read; each then hands off through the finish state.
// Line: setup (with a slope divide for a sloped line), then point, index, address, three byte writes, step per pixel.
// Rectangle: the same pixel steps per pixel plus a row step per row; one command is worked at a time.
// Reset: synchronous; afterwards the frame RAM is zeroed by a clearing pass, req_stall high.
module serpentine_matrix_draw_engine_core #(
   parameter int MATRIX_WIDTH  = sme_pkg::MATRIX_WIDTH_DEF,
   parameter int MATRIX_HEIGHT = sme_pkg::MATRIX_HEIGHT_DEF,
   parameter int STORE_BYTES   = sme_pkg::STORE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_action,
   input  logic signed [7:0] req_start_x,
   input  logic signed [7:0] req_start_y,
   input  logic signed [7:0] req_end_x,
   input  logic signed [7:0] req_end_y,
   input  logic [23:0]       req_pixel_color,
   input  logic [8:0]        req_dim_factor,
   input  logic [10:0]       req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_read_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import sme_pkg::*;

   localparam int MEM_AW = $clog2(STORE_BYTES);
   localparam int CNT_W  = $clog2(STORE_BYTES + 1);
   localparam logic signed [PIX_W-1:0]   W_S   = PIX_W'(MATRIX_WIDTH);
   localparam logic signed [PIX_W-1:0]   H_S   = PIX_W'(MATRIX_HEIGHT);
   localparam logic signed [BADDR_W-1:0] LIM_S = BADDR_W'(STORE_BYTES);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SWEEP, ST_LINE_SETUP, ST_DIV, ST_LINE_POINT, ST_LINE_NEXT,
      ST_RECT_POINT, ST_RECT_NEXT, ST_PT_COORD, ST_PT_ADDR, ST_PT_WR,
      ST_READ_WAIT, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic              init_ff, init_in;
   logic [2:0]        act_ff, act_in;
   logic              snake_ff;
   logic [23:0]       color_ff, color_in;
   logic [8:0]        factor_ff, factor_in;
   logic [7:0]        result_ff, result_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [CNT_W-1:0]  sweep_ff, sweep_in;
   logic              wb_valid_ff, wb_valid_in;
   logic [MEM_AW-1:0] wb_addr_ff, wb_addr_in;
   logic              div_go_ff, div_go_in;
   logic signed [7:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [8:0] t_ff, t_in, e_ff, e_in, rx_ff, rx_in, ry_ff, ry_in;
   logic signed [COORD_W-1:0] o0_ff, o0_in, px_ff, px_in, py_ff, py_in;
   logic              step_y_ff, step_y_in, dneg_ff, dneg_in;
   logic [7:0]        dabs_ff, dabs_in, den_ff, den_in, qa_ff, qa_in, ra_ff, ra_in, r_ff, r_in;
   logic [8:0]        q_ff, q_in;
   logic signed [PIX_W-1:0] p_ff, p_in;
   logic [MEM_AW-1:0] addr_ff, addr_in;
   logic [1:0]        byte_ff, byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;

   // Memory and divider hookup
   logic              mem_wr_en;
   logic [MEM_AW-1:0] mem_wr_addr, mem_rd_addr;
   logic [7:0]        mem_wr_data, mem_rd_data;
   logic              div_start;
   div_result_type    div_res;

   // Scratch values
   logic [15:0]              ridx_ext;
   logic                     in_range;
   logic signed [8:0]        dx, dy, dsel, s_sel, e_sel;
   logic signed [COORD_W-1:0] other;
   logic signed [PIX_W-1:0]  mul_a, mul_k, term;
   logic signed [BADDR_W-1:0] baddr;
   logic [8:0]               rsum;
   logic [7:0]               color_byte;
   state_type                plot_ret;

   sme_frame_mem #(.DEPTH(STORE_BYTES), .ADDR_W(MEM_AW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sme_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dabs_ff),
      .divisor  (den_ff),
      .result   (div_res)
   );

   assign ridx_ext  = 16'(req_read_index);
   assign in_range  = sweep_ff < CNT_W'(STORE_BYTES);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // Where a finished pixel returns to
   always_comb begin
      case (act_ff)
         ACT_LINE: plot_ret = ST_LINE_NEXT;
         ACT_RECT: plot_ret = ST_RECT_NEXT;
         default:  plot_ret = ST_FINISH;
      endcase
   end

   // Color byte for the current write
   always_comb begin
      case (byte_ff)
         2'd0:    color_byte = color_ff[23:16];
         2'd1:    color_byte = color_ff[15:8];
         default: color_byte = color_ff[7:0];
      endcase
   end

   // Line setup: pick stepping axis, span and slope
   always_comb begin
      dx = 9'(ex_ff) - 9'(sx_ff);
      dy = 9'(ey_ff) - 9'(sy_ff);
      if (sx_ff == ex_ff) begin
         s_sel = (sy_ff < ey_ff) ? 9'(sy_ff) : 9'(ey_ff);
         e_sel = (sy_ff < ey_ff) ? 9'(ey_ff) : 9'(sy_ff);
         dsel  = 9'sd0;
      end else if (sy_ff == ey_ff) begin
         s_sel = (sx_ff < ex_ff) ? 9'(sx_ff) : 9'(ex_ff);
         e_sel = (sx_ff < ex_ff) ? 9'(ex_ff) : 9'(sx_ff);
         dsel  = 9'sd0;
      end else if (dy > dx) begin
         s_sel = 9'(sy_ff);
         e_sel = 9'(ey_ff);
         dsel  = dx;
      end else begin
         s_sel = 9'(sx_ff);
         e_sel = 9'(ex_ff);
         dsel  = dy;
      end
   end

   // Point on the line for the current step
   assign other = o0_ff + (dneg_ff ? -COORD_W'(q_ff) : COORD_W'(q_ff));
   assign rsum  = 9'(r_ff) + 9'(ra_ff);

   // Snake index: one multiply by the row or column length plus an offset
   always_comb begin
      if (!snake_ff) begin
         mul_a = PIX_W'(py_ff);
         mul_k = W_S;
         term  = py_ff[0] ? (W_S - 18'sd1 - PIX_W'(px_ff)) : PIX_W'(px_ff);
      end else begin
         mul_a = px_ff[0] ? (PIX_W'(px_ff) + 18'sd1) : PIX_W'(px_ff);
         mul_k = H_S;
         term  = px_ff[0] ? (-18'sd1 - PIX_W'(py_ff)) : PIX_W'(py_ff);
      end
   end

   assign baddr = (BADDR_W'(p_ff) <<< 1) + BADDR_W'(p_ff);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      init_in     = init_ff;
      act_in      = act_ff;
      color_in    = color_ff;
      factor_in   = factor_ff;
      result_in   = result_ff;
      rd_ok_in    = rd_ok_ff;
      sweep_in    = sweep_ff;
      wb_valid_in = 1'b0;
      wb_addr_in  = sweep_ff[MEM_AW-1:0];
      div_go_in   = 1'b0;
      sx_in = sx_ff; sy_in = sy_ff; ex_in = ex_ff; ey_in = ey_ff;
      t_in = t_ff; e_in = e_ff; rx_in = rx_ff; ry_in = ry_ff;
      o0_in = o0_ff; px_in = px_ff; py_in = py_ff;
      step_y_in = step_y_ff; dneg_in = dneg_ff; dabs_in = dabs_ff; den_in = den_ff;
      qa_in = qa_ff; ra_in = ra_ff; r_in = r_ff; q_in = q_ff;
      p_in     = p_ff;
      addr_in  = addr_ff;
      byte_in  = byte_ff;
      div_start   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff + MEM_AW'(byte_ff);
      mem_wr_data = color_byte;
      mem_rd_addr = ridx_ext[MEM_AW-1:0];
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in    = req_action;
               color_in  = req_pixel_color;
               factor_in = req_dim_factor;
               result_in = 8'd0;
               rd_ok_in  = ridx_ext < 16'(STORE_BYTES);
               sx_in = req_start_x; sy_in = req_start_y;
               ex_in = req_end_x;   ey_in = req_end_y;
               px_in = COORD_W'(req_start_x);
               py_in = COORD_W'(req_start_y);
               rx_in = 9'(req_start_x);
               ry_in = 9'(req_start_y);
               sweep_in = '0;
               case (req_action)
                  ACT_CLEAR: state_in = ST_SWEEP;
                  ACT_DIM:   state_in = ST_SWEEP;
                  ACT_POINT: state_in = ST_PT_COORD;
                  ACT_LINE:  state_in = ST_LINE_SETUP;
                  ACT_RECT:  state_in = ST_RECT_POINT;
                  ACT_READ:  state_in = ST_READ_WAIT;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
         ST_SWEEP: begin
            // read byte n while writing back byte n-1 (dim) or zeroing byte n (clear)
            mem_rd_addr = sweep_ff[MEM_AW-1:0];
            if (act_ff == ACT_DIM) begin
               mem_wr_en   = wb_valid_ff;
               mem_wr_addr = wb_addr_ff;
               mem_wr_data = dim_byte(mem_rd_data, factor_ff);
               wb_valid_in = in_range;
            end else begin
               mem_wr_en   = in_range;
               mem_wr_addr = sweep_ff[MEM_AW-1:0];
               mem_wr_data = 8'd0;
            end
            if (in_range) begin
               sweep_in = sweep_ff + CNT_W'(1);
            end else if (!wb_valid_ff) begin
               init_in  = 1'b0;
               state_in = init_ff ? ST_IDLE : ST_FINISH;
            end
         end
         ST_LINE_SETUP: begin
            step_y_in = (sx_ff == ex_ff) || ((sy_ff != ey_ff) && (dy > dx));
            t_in    = s_sel;
            e_in    = e_sel;
            o0_in   = (sx_ff == ex_ff) || ((sy_ff != ey_ff) && (dy > dx)) ?
                      COORD_W'(sx_ff) : COORD_W'(sy_ff);
            dneg_in = dsel[8];
            dabs_in = dsel[8] ? 8'(-dsel) : dsel[7:0];
            den_in  = 8'(e_sel - s_sel);
            q_in  = 9'd0;
            r_in  = 8'd0;
            qa_in = 8'd0;
            ra_in = 8'd0;
            if ((e_sel > s_sel) && (dsel != 9'sd0)) begin
               div_go_in = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_LINE_POINT;
            end
         end
         ST_DIV: begin
            // start on entry, wait for done
            div_start = div_go_ff;
            if (div_res.done) begin
               qa_in    = div_res.quotient;
               ra_in    = div_res.remainder;
               state_in = ST_LINE_POINT;
            end
         end
         ST_LINE_POINT: begin
            if (t_ff >= e_ff) begin
               state_in = ST_FINISH;
            end else begin
               px_in    = step_y_ff ? other : COORD_W'(t_ff);
               py_in    = step_y_ff ? COORD_W'(t_ff) : other;
               state_in = ST_PT_COORD;
            end
         end
         ST_LINE_NEXT: begin
            t_in = t_ff + 9'sd1;
            if (rsum >= 9'(den_ff)) begin
               r_in = 8'(rsum - 9'(den_ff));
               q_in = q_ff + 9'(qa_ff) + 9'd1;
            end else begin
               r_in = rsum[7:0];
               q_in = q_ff + 9'(qa_ff);
            end
            state_in = ST_LINE_POINT;
         end
         ST_RECT_POINT: begin
            if (ry_ff >= 9'(ey_ff)) begin
               state_in = ST_FINISH;
            end else if (rx_ff >= 9'(ex_ff)) begin
               ry_in = ry_ff + 9'sd1;
               rx_in = 9'(sx_ff);
            end else begin
               px_in    = COORD_W'(rx_ff);
               py_in    = COORD_W'(ry_ff);
               state_in = ST_PT_COORD;
            end
         end
         ST_RECT_NEXT: begin
            rx_in    = rx_ff + 9'sd1;
            state_in = ST_RECT_POINT;
         end
         ST_PT_COORD: begin
            p_in     = mul_a * mul_k + term;
            state_in = ST_PT_ADDR;
         end
         ST_PT_ADDR: begin
            addr_in = baddr[MEM_AW-1:0];
            byte_in = 2'd0;
            if ((baddr >= 20'sd0) && (baddr + 20'sd3 <= LIM_S)) begin
               state_in = ST_PT_WR;
            end else begin
               state_in = plot_ret;
            end
         end
         ST_PT_WR: begin
            mem_wr_en = 1'b1;
            byte_in   = byte_ff + 2'd1;
            if (byte_ff == 2'd2) begin
               state_in = plot_ret;
            end
         end
         ST_READ_WAIT: begin
            result_in = rd_ok_ff ? mem_rd_data : 8'd0;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         init_ff      <= 1'b1;
         act_ff       <= ACT_CLEAR;
         sweep_ff     <= '0;
         wb_valid_ff  <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         snake_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         act_ff       <= act_in;
         sweep_ff     <= sweep_in;
         wb_valid_ff  <= wb_valid_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            snake_ff <= csr_wr_data;
         end
      end
      color_ff <= color_in; factor_ff <= factor_in; result_ff <= result_in;
      rd_ok_ff <= rd_ok_in; wb_addr_ff <= wb_addr_in;
      sx_ff <= sx_in; sy_ff <= sy_in; ex_ff <= ex_in; ey_ff <= ey_in;
      t_ff <= t_in; e_ff <= e_in; rx_ff <= rx_in; ry_ff <= ry_in;
      o0_ff <= o0_in; px_ff <= px_in; py_ff <= py_in;
      step_y_ff <= step_y_in; dneg_ff <= dneg_in; dabs_ff <= dabs_in; den_ff <= den_in;
      qa_ff <= qa_in; ra_ff <= ra_in; r_ff <= r_in; q_ff <= q_in;
      p_ff <= p_in; addr_ff <= addr_in; byte_ff <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared outside finish");

   a_wr_states: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_SWEEP || state_ff == ST_PT_WR))
      else $error("frame write outside sweep or pixel write");

   a_pix_in_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PT_WR) |-> (32'(mem_wr_addr) < 32'(STORE_BYTES)))
      else $error("pixel byte past end of frame store");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second command taken while busy");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside slope setup");

endmodule

/* rtl/sme_frame_mem.sv */
module sme_frame_mem #(
   parameter int DEPTH  = 1536,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_array [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_array[rd_addr];
   end

endmodule

/* rtl/sme_divider.sv */
module sme_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [7:0]             dividend,
   input  logic [7:0]             divisor,
   output sme_pkg::div_result_type result
);
   import sme_pkg::*;

   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] num_ff, num_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] den_ff, den_in;
   logic [8:0] shifted;

   // One restoring step per cycle, quotient bits shift into num
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      shifted = {rem_ff, num_ff[7]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         num_in  = dividend;
         rem_in  = 8'd0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = 8'(shifted - {1'b0, den_ff});
            num_in = {num_ff[6:0], 1'b1};
         end else begin
            rem_in = shifted[7:0];
            num_in = {num_ff[6:0], 1'b0};
         end
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = num_ff;
   assign result.remainder = rem_ff;

endmodule
